// ===== rtl/vdp_pkg.sv =====
// shared types and constants of the vga dac palette register block
// no dependencies; used by vdp_regs and vga_dac_palette_registers_top
`default_nettype none

package vdp_pkg;

	// byte width of the bus ports
	localparam int DATA_W = 8;

	// request kinds
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// port codes
	typedef enum logic [1:0] {
		PORT_MASK  = 2'd0,
		PORT_STATE = 2'd1,
		PORT_WADDR = 2'd2,
		PORT_DATA  = 2'd3
	} port_t;

	// component codes inside a pointer
	localparam logic [1:0] COMP_RED  = 2'd0;
	localparam logic [1:0] COMP_BLUE = 2'd2;

	// dac state readback and mask reset
	localparam logic [DATA_W-1:0] STATE_READ_MODE  = 8'h03;
	localparam logic [DATA_W-1:0] STATE_WRITE_MODE = 8'h00;
	localparam logic [DATA_W-1:0] PIXEL_MASK_RESET = 8'hFF;

	// decoded response of one transfer, waiting for the palette read
	typedef struct packed {
		logic              palette_rd;
		logic [DATA_W-1:0] reg_data;
	} resp_t;

endpackage

`default_nettype wire

// ===== rtl/vdp_palette_ram.sv =====
// palette memory: one write port, one read port with registered data
// no dependencies
`default_nettype none

module vdp_palette_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int WORD_W = 6
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WORD_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vdp_regs.sv =====
// port decoder, read and write pointers, pixel mask, dac mode and clear sweep
// depends on vdp_pkg; drives the palette memory ports
`default_nettype none

module vdp_regs #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int COMPONENT_BITS  = 6,
	parameter int ADDR_W          = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       xfer,
	input  wire logic                       req_type,
	input  wire logic [1:0]                 port_select,
	input  wire logic [vdp_pkg::DATA_W-1:0] write_data,
	output logic                            clear_busy,
	output logic                            mem_wr_en,
	output logic      [ADDR_W-1:0]          mem_wr_addr,
	output logic      [COMPONENT_BITS-1:0]  mem_wr_data,
	output logic                            mem_rd_en,
	output logic      [ADDR_W-1:0]          mem_rd_addr,
	output vdp_pkg::resp_t                  resp
);

	localparam int EntryW   = ADDR_W - 2;
	localparam int LastWord = 4 * PALETTE_ENTRIES - 1;

	logic [EntryW-1:0]          rptr_entry_q, wptr_entry_q;
	logic [1:0]                 rptr_comp_q, wptr_comp_q;
	logic [vdp_pkg::DATA_W-1:0] mask_q;
	logic                       read_mode_q;
	logic                       clear_busy_q;
	logic [ADDR_W-1:0]          clr_addr_q;

	logic                       is_write;
	vdp_pkg::port_t             port;
	logic                       data_wr, data_rd;
	logic [EntryW-1:0]          load_entry;

	// byte reduced modulo the entry count by four compare and subtract steps
	function automatic logic [EntryW-1:0] entry_of(input logic [vdp_pkg::DATA_W-1:0] v);
		logic [11:0] r;
		r = 12'(v);
		for (int k = 3; k >= 0; k--) begin
			if (r >= 12'(PALETTE_ENTRIES << k)) begin
				r = r - 12'(PALETTE_ENTRIES << k);
			end
		end
		return r[EntryW-1:0];
	endfunction

	// next entry with wrap after the last one
	function automatic logic [EntryW-1:0] next_entry(input logic [EntryW-1:0] e);
		logic [EntryW-1:0] n;
		n = (e == EntryW'(PALETTE_ENTRIES - 1)) ? '0 : e + 1'b1;
		return n;
	endfunction

	// request decode
	assign is_write   = (req_type == vdp_pkg::REQ_WRITE);
	assign port       = vdp_pkg::port_t'(port_select);
	assign data_wr    = xfer && is_write && (port == vdp_pkg::PORT_DATA);
	assign data_rd    = xfer && !is_write && (port == vdp_pkg::PORT_DATA);
	assign load_entry = entry_of(write_data);

	// memory ports: clear sweep owns the write port after reset
	assign clear_busy  = clear_busy_q;
	assign mem_wr_en   = clear_busy_q || data_wr;
	assign mem_wr_addr = clear_busy_q ? clr_addr_q : {wptr_entry_q, wptr_comp_q};
	assign mem_wr_data = clear_busy_q ? '0 : write_data[COMPONENT_BITS-1:0];
	assign mem_rd_en   = data_rd;
	assign mem_rd_addr = {rptr_entry_q, rptr_comp_q};

	// register readback
	always_comb begin
		resp.palette_rd = data_rd;
		resp.reg_data   = '0;
		if (!is_write) begin
			case (port)
				vdp_pkg::PORT_MASK:  resp.reg_data = mask_q;
				vdp_pkg::PORT_STATE: resp.reg_data = read_mode_q ? vdp_pkg::STATE_READ_MODE
				                                                 : vdp_pkg::STATE_WRITE_MODE;
				vdp_pkg::PORT_WADDR: resp.reg_data = vdp_pkg::DATA_W'(wptr_entry_q);
				default:             resp.reg_data = '0;
			endcase
		end
	end

	// clear sweep over every memory word after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clear_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(LastWord)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	// pointers, mask and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_entry_q <= '0;
			rptr_comp_q  <= vdp_pkg::COMP_RED;
			wptr_entry_q <= '0;
			wptr_comp_q  <= vdp_pkg::COMP_RED;
			mask_q       <= vdp_pkg::PIXEL_MASK_RESET;
			read_mode_q  <= 1'b0;
		end else if (xfer) begin
			if (is_write) begin
				case (port)
					vdp_pkg::PORT_MASK: mask_q <= write_data;
					vdp_pkg::PORT_STATE: begin
						rptr_entry_q <= load_entry;
						rptr_comp_q  <= vdp_pkg::COMP_RED;
						read_mode_q  <= 1'b1;
					end
					vdp_pkg::PORT_WADDR: begin
						wptr_entry_q <= load_entry;
						wptr_comp_q  <= vdp_pkg::COMP_RED;
						read_mode_q  <= 1'b0;
					end
					default: begin
						if (wptr_comp_q >= vdp_pkg::COMP_BLUE) begin
							wptr_entry_q <= next_entry(wptr_entry_q);
							wptr_comp_q  <= vdp_pkg::COMP_RED;
						end else begin
							wptr_comp_q <= wptr_comp_q + 1'b1;
						end
					end
				endcase
			end else if (port == vdp_pkg::PORT_DATA) begin
				if (rptr_comp_q >= vdp_pkg::COMP_BLUE) begin
					rptr_entry_q <= next_entry(rptr_entry_q);
					rptr_comp_q  <= vdp_pkg::COMP_RED;
				end else begin
					rptr_comp_q <= rptr_comp_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vga_dac_palette_registers_top.sv =====
// top level of the vga dac palette register block: handshake, result pipeline
// depends on vdp_pkg, vdp_regs and vdp_palette_ram
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, req_type, port_select, | into block
//           | write_data                                |
//   out     | out_valid, out_ready, read_data            | out of block
//
// one bus access per transfer, one result per access; a new access can be
// taken every cycle while the output is not stalled and no clear sweep runs;
// the result passes stage 1 and the output register; palette data is read from
// the registered memory port at the transfer and moves to the output register.
// after reset a clear sweep writes zero to all 4 * PALETTE_ENTRIES memory
// words (1024 at the default size) with in_ready low.
// a stalled output holds the result; one more access is taken into stage 1.
`default_nettype none

module vga_dac_palette_registers_top #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int COMPONENT_BITS  = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       req_type,
	input  wire logic [1:0]                 port_select,
	input  wire logic [vdp_pkg::DATA_W-1:0] write_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [vdp_pkg::DATA_W-1:0] read_data
);

	localparam int EntryW = $clog2(PALETTE_ENTRIES);
	localparam int AddrW  = EntryW + 2;
	localparam int Depth  = 4 * PALETTE_ENTRIES;

	logic                      xfer, out_free, clear_busy;
	logic                      mem_wr_en, mem_rd_en;
	logic [AddrW-1:0]          mem_wr_addr, mem_rd_addr;
	logic [COMPONENT_BITS-1:0] mem_wr_data, mem_rd_data;
	vdp_pkg::resp_t            resp, resp_s1;
	logic                      valid_s1_q;
	logic                      out_valid_q;
	logic [vdp_pkg::DATA_W-1:0] read_data_q;

	vdp_regs #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.COMPONENT_BITS (COMPONENT_BITS),
		.ADDR_W         (AddrW)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.xfer       (xfer),
		.req_type   (req_type),
		.port_select(port_select),
		.write_data (write_data),
		.clear_busy (clear_busy),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.resp       (resp)
	);

	vdp_palette_ram #(
		.DEPTH (Depth),
		.ADDR_W(AddrW),
		.WORD_W(COMPONENT_BITS)
	) u_ram (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// handshake
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !clear_busy && (!valid_s1_q || out_free);
	assign xfer      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	// stage 1 control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1_q  <= xfer || (valid_s1_q && !out_free);
			out_valid_q <= (valid_s1_q && out_free) || (out_valid_q && !out_ready);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (xfer) begin
			resp_s1 <= resp;
		end
	end

	// output register, palette data or register readback
	always_ff @(posedge clk) begin
		if (valid_s1_q && out_free) begin
			read_data_q <= resp_s1.palette_rd ? vdp_pkg::DATA_W'(mem_rd_data)
			                                  : resp_s1.reg_data;
		end
	end

	// the clear sweep runs only once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_busy |=> !clear_busy)
		else $error("clear sweep restarted");

	// a held stage 1 item blocks new transfers
	a_s1_block: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1_q && !out_free) |-> !in_ready)
		else $error("stage 1 overwritten");

	// every transfer lands in stage 1
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |=> valid_s1_q)
		else $error("transfer lost");

	// no palette read while the memory is being cleared
	a_no_rd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !mem_rd_en)
		else $error("palette read during clear sweep");

endmodule

`default_nettype wire
